/* rtl/tplg_pkg.sv */
package tplg_pkg;

  localparam int COORD_WIDTH_DEF   = 24;
  localparam int FRACTION_BITS_DEF = 8;

  // Bit positions of the result flags in the output tuser
  localparam int USER_VERTICAL = 0;
  localparam int USER_SATURATE = 1;
  localparam int USER_WIDTH    = 2;

  // Round a bit count up to whole bytes
  function automatic int byte_bits(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

/* rtl/tplg_front.sv */
module tplg_front #(
  parameter int W = tplg_pkg::COORD_WIDTH_DEF,
  parameter int F = tplg_pkg::FRACTION_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [tplg_pkg::byte_bits(4*W)-1:0]    in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [6*W+1:0]                         out_entry
);
  import tplg_pkg::*;

  logic [W-1:0] x1, y1, x2, y2;
  logic [W:0]   dx, dy, ndx, ndy, sx, sy, msx, msy;
  logic [W+1:0] hx, hy;
  logic [W-1:0] mag_dx, mag_dy, mid_x, mid_y;
  logic         neg, vert;
  logic [6*W+1:0] entry_next;

  logic           valid;
  logic [6*W+1:0] entry;

  assign x1 = in_data[W-1:0];
  assign y1 = in_data[2*W-1:W];
  assign x2 = in_data[3*W-1:2*W];
  assign y2 = in_data[4*W-1:3*W];

  always_comb begin
    dx  = {x1[W-1], x1} - {x2[W-1], x2};
    dy  = {y1[W-1], y1} - {y2[W-1], y2};
    ndx = -dx;
    ndy = -dy;
    mag_dx = dx[W] ? ndx[W-1:0] : dx[W-1:0];
    mag_dy = dy[W] ? ndy[W-1:0] : dy[W-1:0];
    neg  = (dx[W] != dy[W]) && (dy != '0);
    vert = (dx == '0);
    // midpoint: halve the magnitude with rounding, then restore the sign
    sx  = {x1[W-1], x1} + {x2[W-1], x2};
    sy  = {y1[W-1], y1} + {y2[W-1], y2};
    msx = sx[W] ? -sx : sx;
    msy = sy[W] ? -sy : sy;
    hx  = ({1'b0, msx} + {{(W+1){1'b0}}, 1'b1}) >> 1;
    hy  = ({1'b0, msy} + {{(W+1){1'b0}}, 1'b1}) >> 1;
    mid_x = sx[W] ? -hx[W-1:0] : hx[W-1:0];
    mid_y = sy[W] ? -hy[W-1:0] : hy[W-1:0];
    entry_next = {mid_y, mid_x, y1, x1, vert, neg, mag_dy, mag_dx};
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      entry <= entry_next;
    end
  end

endmodule

/* rtl/tplg_queue.sv */
module tplg_queue #(
  parameter int EW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [EW-1:0] in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [EW-1:0] out_data
);
  import tplg_pkg::*;

  logic [EW-1:0] slots [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;
  logic          push, pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slots[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

/* rtl/tplg_back.sv */
module tplg_back #(
  parameter int W = tplg_pkg::COORD_WIDTH_DEF,
  parameter int F = tplg_pkg::FRACTION_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [6*W+1:0]                         in_entry,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [tplg_pkg::byte_bits(5*W+1)-1:0]  out_data,
  output logic [tplg_pkg::USER_WIDTH-1:0]        out_user
);
  import tplg_pkg::*;

  localparam int AW   = W + F + 2;   // dividend (2*num + den) width and quotient width
  localparam int RW   = W + 1;       // root width
  localparam int SQW  = 2 * RW;      // sum of squares width
  localparam int RRW  = RW + 2;      // root remainder width
  localparam int NS   = AW;          // shared stages of divider and root
  localparam int SBW  = 4 * W + 2;
  localparam int NW   = 2 * W + F + 1;
  localparam int ODW  = byte_bits(5 * W + 1);

  logic en;

  // entry stage: squares and divider operands
  logic           p0_v;
  logic [2*W-1:0] p0_dxsq, p0_dysq;
  logic [AW-1:0]  p0_a;
  logic [W:0]     p0_b;
  logic [SBW-1:0] p0_sb;

  logic           v   [NS+1];
  logic [AW-1:0]  da  [NS+1];
  logic [W:0]     dr  [NS+1];
  logic [AW-1:0]  dq  [NS+1];
  logic [W:0]     db  [NS+1];
  logic [SQW-1:0] ss  [NS+1];
  logic [RRW-1:0] sr  [NS+1];
  logic [RW-1:0]  rt  [NS+1];
  logic [SBW-1:0] sb  [NS+1];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_v <= 1'b0;
      v[0] <= 1'b0;
    end else if (en) begin
      p0_v <= in_valid;
      v[0] <= p0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_dxsq <= in_entry[W-1:0] * in_entry[W-1:0];
      p0_dysq <= in_entry[2*W-1:W] * in_entry[2*W-1:W];
      p0_a    <= (AW'(in_entry[2*W-1:W]) << (F + 1)) + AW'(in_entry[W-1:0]);
      p0_b    <= {in_entry[W-1:0], 1'b0};
      p0_sb   <= in_entry[6*W+1:2*W];
      da[0]   <= p0_a;
      dr[0]   <= '0;
      dq[0]   <= '0;
      db[0]   <= p0_b;
      ss[0]   <= SQW'(p0_dxsq) + SQW'(p0_dysq);
      sr[0]   <= '0;
      rt[0]   <= '0;
      sb[0]   <= p0_sb;
    end
  end

  // one quotient bit and, in the first RW stages, one root bit per stage
  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [W+1:0]   dt, dd;
    logic           qb;
    logic [RRW+1:0] st, trial, sd;
    logic           rb;

    assign dt = {dr[k], da[k][AW-1]};
    assign dd = dt - {1'b0, db[k]};
    assign qb = (dt >= {1'b0, db[k]});
    assign st    = {sr[k], ss[k][SQW-1 -: 2]};
    assign trial = {2'b00, rt[k], 2'b01};
    assign sd    = st - trial;
    assign rb    = (st >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        da[k+1] <= da[k] << 1;
        dr[k+1] <= qb ? dd[W:0] : dt[W:0];
        dq[k+1] <= {dq[k][AW-2:0], qb};
        db[k+1] <= db[k];
        sb[k+1] <= sb[k];
        if (k < RW) begin
          ss[k+1] <= ss[k] << 2;
          sr[k+1] <= rb ? sd[RRW-1:0] : st[RRW-1:0];
          rt[k+1] <= {rt[k][RW-2:0], rb};
        end else begin
          ss[k+1] <= ss[k];
          sr[k+1] <= sr[k];
          rt[k+1] <= rt[k];
        end
      end
    end
  end

  // slope saturation and distance rounding
  logic          neg_f, vert_f, hi_nz, s_clip_next;
  logic [W-1:0]  q_lo, slope_next;
  logic [RW-1:0] span_next;

  logic          s_v, s_vert, s_clip;
  logic [W-1:0]  s_slope, s_x1, s_y1, s_midx, s_midy;
  logic [RW-1:0] s_span;

  always_comb begin
    neg_f  = sb[NS][0];
    vert_f = sb[NS][1];
    q_lo   = dq[NS][W-1:0];
    hi_nz  = |dq[NS][AW-1:W];
    if (neg_f) begin
      s_clip_next = hi_nz || (q_lo[W-1] && (|q_lo[W-2:0]));
      slope_next  = s_clip_next ? {1'b1, {(W-1){1'b0}}} : -q_lo;
    end else begin
      s_clip_next = hi_nz || q_lo[W-1];
      slope_next  = s_clip_next ? {1'b0, {(W-1){1'b1}}} : q_lo;
    end
    if (vert_f) begin
      s_clip_next = 1'b0;
      slope_next  = '0;
    end
    span_next = rt[NS] + {{(RW-1){1'b0}}, (sr[NS] > {2'b00, rt[NS]})};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_v <= 1'b0;
    end else if (en) begin
      s_v <= v[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_vert  <= vert_f;
      s_clip  <= s_clip_next;
      s_slope <= slope_next;
      s_x1    <= sb[NS][W+1:2];
      s_y1    <= sb[NS][2*W+1:W+2];
      s_midx  <= sb[NS][3*W+1:2*W+2];
      s_midy  <= sb[NS][4*W+1:3*W+2];
      s_span  <= span_next;
    end
  end

  // slope times x1
  logic                  m_v, m_vert, m_clip;
  logic signed [2*W-1:0] m_prod;
  logic [W-1:0]          m_slope, m_y1, m_midx, m_midy;
  logic [RW-1:0]         m_span;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (en) begin
      m_v <= s_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_prod  <= $signed(s_slope) * $signed(s_x1);
      m_vert  <= s_vert;
      m_clip  <= s_clip;
      m_slope <= s_slope;
      m_y1    <= s_y1;
      m_midx  <= s_midx;
      m_midy  <= s_midy;
      m_span  <= s_span;
    end
  end

  // intercept rounding and saturation, output register
  localparam logic [NW-1:0] HALF = ({{(NW-1){1'b0}}, 1'b1} << F) >> 1;
  localparam logic [NW-1:0] LIM  = {{(NW-1){1'b0}}, 1'b1} << (W - 1);

  logic [NW-1:0]  y_sh, num, mag_n, qi;
  logic           nn, iclip;
  logic [W-1:0]   icpt;
  logic [ODW-1:0] data_next;
  logic [USER_WIDTH-1:0] user_next;

  always_comb begin
    y_sh  = {{(W+F+1){m_y1[W-1]}}, m_y1} << F;
    num   = y_sh - {{(F+1){m_prod[2*W-1]}}, m_prod};
    nn    = num[NW-1];
    mag_n = nn ? -num : num;
    qi    = (mag_n + HALF) >> F;
    if (nn) begin
      iclip = (qi > LIM);
      icpt  = iclip ? {1'b1, {(W-1){1'b0}}} : -qi[W-1:0];
    end else begin
      iclip = (qi >= LIM);
      icpt  = iclip ? {1'b0, {(W-1){1'b1}}} : qi[W-1:0];
    end
    if (m_vert) begin
      iclip = 1'b0;
      icpt  = '0;
    end
    data_next = '0;
    data_next[W-1:0]       = m_slope;
    data_next[2*W-1:W]     = m_midx;
    data_next[3*W-1:2*W]   = m_midy;
    data_next[4*W:3*W]     = m_span;
    data_next[5*W:4*W+1]   = icpt;
    user_next = '0;
    user_next[USER_VERTICAL] = m_vert;
    user_next[USER_SATURATE] = m_clip || iclip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
      out_user <= user_next;
    end
  end

endmodule

/* rtl/two_point_line_geometry.sv */
// Line through two points: slope, midpoint, distance and y-intercept.
// Input stream s_*: one item holds two points in signed fixed point with
// FRACTION_BITS fractional bits. Output stream m_*: one result item for
// each input item, in order.
// The divider resolves one quotient bit per stage, and the square root
// runs in the same stages.
// Throughput: one item per cycle while m_tready stays high.
// A front stage takes items in and forms differences, magnitudes and the
// midpoint; a two-entry queue separates it from the arithmetic pipeline.
// When m_tready drops, the whole arithmetic pipeline holds; the front keeps
// accepting until the queue and its own register are full, then drops
// s_tready. Reset (rst, synchronous) empties every stage and the queue.
module two_point_line_geometry #(
  parameter int COORD_WIDTH   = tplg_pkg::COORD_WIDTH_DEF,
  parameter int FRACTION_BITS = tplg_pkg::FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // x_first, y_first, x_second, y_second
  input  logic [tplg_pkg::byte_bits(4*COORD_WIDTH)-1:0]   s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // slope_value, mid_x, mid_y, span_length, y_intercept, zero fill
  output logic [tplg_pkg::byte_bits(5*COORD_WIDTH+1)-1:0] m_tdata,
  // is_vertical, did_saturate
  output logic [tplg_pkg::USER_WIDTH-1:0]                 m_tuser
);
  import tplg_pkg::*;

  localparam int EW = 6 * COORD_WIDTH + 2;

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [EW-1:0] f_entry, b_entry;

  tplg_front #(.W(COORD_WIDTH), .F(FRACTION_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_entry (f_entry)
  );

  tplg_queue #(.EW(EW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_entry),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_entry)
  );

  tplg_back #(.W(COORD_WIDTH), .F(FRACTION_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .in_entry  (b_entry),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

  a_vert_slope_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_VERTICAL] |-> m_tdata[COORD_WIDTH-1:0] == '0)
    else $error("vertical line with nonzero slope");

  a_vert_no_clip: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_VERTICAL] |-> !m_tuser[USER_SATURATE])
    else $error("vertical line flagged as saturated");

  a_stall_holds_queue: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !b_ready)
    else $error("arithmetic pipeline advanced while output stalled");

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import tplg_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int FB = FRACTION_BITS_DEF;
  localparam int IN_W = byte_bits(4*CW);
  localparam int OUT_W = byte_bits(5*CW+1);
  localparam int LATENCY = CW + FB + 9;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int N_RANDOM = 1430;
  localparam int QUIET_TAIL = 200;

  typedef struct packed {
    logic [CW-1:0] y2;
    logic [CW-1:0] x2;
    logic [CW-1:0] y1;
    logic [CW-1:0] x1;
  } point_pair_t;

  typedef struct {
    logic [CW-1:0] slope;
    logic [CW-1:0] mx;
    logic [CW-1:0] my;
    logic [CW:0]   span;
    logic [CW-1:0] icpt;
    logic          vert;
    logic          sat;
  } line_info_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_W-1:0] m_tdata;
  logic [USER_WIDTH-1:0] m_tuser;

  two_point_line_geometry dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  point_pair_t pending_pairs[$];
  line_info_t  expected_lines[$];
  int mismatches = 0;
  int results_seen = 0;
  int pairs_sent = 0;
  int vertical_seen = 0;
  int saturated_seen = 0;
  int idle_cycles = 0;
  bit stimulus_done = 0;
  bit quiet = 0;
  bit hold_off = 0;
  int send_gap = 0;
  int recv_gap = 0;

  function automatic longint rdiv(bit neg, longint mag, longint den);
    longint q;
    q = (2*mag + den) / (2*den);
    return neg ? -q : q;
  endfunction

  function automatic longint clip(longint v, ref bit clipped);
    longint hi, lo;
    hi = (longint'(1) << (CW-1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      clipped = 1;
      return hi;
    end
    if (v < lo) begin
      clipped = 1;
      return lo;
    end
    return v;
  endfunction

  function automatic line_info_t predict_line(point_pair_t p);
    line_info_t r;
    longint x1, y1, x2, y2, dx, dy, slope, icpt, num, sx, sy;
    longint unsigned adx, ady, sq, root, bitv, rem;
    bit clipped;
    x1 = longint'($signed(p.x1));
    y1 = longint'($signed(p.y1));
    x2 = longint'($signed(p.x2));
    y2 = longint'($signed(p.y2));
    dx = x1 - x2;
    dy = y1 - y2;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    slope = 0;
    icpt = 0;
    clipped = 0;
    if (dx != 0) begin
      slope = rdiv(((dx < 0) != (dy < 0)) && dy != 0, longint'(ady << FB), adx);
      slope = clip(slope, clipped);
      num = (y1 <<< FB) - slope * x1;
      icpt = rdiv(num < 0, num < 0 ? -num : num, longint'(1) << FB);
      icpt = clip(icpt, clipped);
    end
    sx = x1 + x2;
    sy = y1 + y2;
    sx = rdiv(sx < 0, sx < 0 ? -sx : sx, 2);
    sy = rdiv(sy < 0, sy < 0 ? -sy : sy, 2);
    sq = adx*adx + ady*ady;
    rem = sq;
    root = 0;
    bitv = longint'(1) << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    if (sq - root*root > root) root++;
    r.slope = slope[CW-1:0];
    r.mx = sx[CW-1:0];
    r.my = sy[CW-1:0];
    r.span = root[CW:0];
    r.icpt = icpt[CW-1:0];
    r.vert = (dx == 0);
    r.sat = clipped;
    return r;
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 4) == 0 ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      1: return CW'($signed($urandom_range(0, 600)) - 300);
      2: return CW'($signed($urandom_range(0, 60000)) - 30000);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic point_pair_t rand_pair();
    point_pair_t p;
    p.x1 = rand_coord();
    p.y1 = rand_coord();
    p.x2 = rand_coord();
    p.y2 = rand_coord();
    case ($urandom_range(0, 9))
      0: p.x2 = p.x1;
      1: begin
        p.x2 = p.x1 + CW'($urandom_range(1, 2));
        p.y2 = CW'($urandom);
      end
      2: p = '{y2: p.y1, x2: p.x1, y1: p.y1, x1: p.x1};
      default: ;
    endcase
    return p;
  endfunction

  task automatic add_pair(int x1, int y1, int x2, int y2);
    pending_pairs.push_back('{y2: CW'(y2), x2: CW'(x2), y1: CW'(y1), x1: CW'(x1)});
  endtask

  initial begin
    int mx, mn;
    mx = (1 << (CW-1)) - 1;
    mn = -(1 << (CW-1));
    add_pair(0, 0, 0, 0);
    add_pair(256, 512, 256, -512);
    add_pair(mx, mx, mn, mn);
    add_pair(mn, mn, mx, mx);
    add_pair(mx, mn, mx - 1, mx);
    add_pair(mn, mx, mn + 1, mn);
    add_pair(0, mx, 1, mn);
    add_pair(mx, mx, mx, mx);
    add_pair(mn, mn, mn, mn);
    add_pair(-1, 0, 0, -1);
    add_pair(1, 1, 2, 2);
    add_pair(3, 1, 1, 0);
    add_pair(-3, -1, -1, 0);
    add_pair(256, 256, 768, 1024);
    add_pair(-768, 300, 512, -700);
    add_pair(mx, 0, -mx, 1);
    add_pair(100, mx, 101, mn);
    add_pair(1000, 5, -1000, 7);
    add_pair(mx, mn, mn, mx);
    add_pair(-1, -1, -2, -3);
    for (int i = 0; i < N_RANDOM; i++) pending_pairs.push_back(rand_pair());
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
  end

  // Driver
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_lines.push_back(predict_line(point_pair_t'(s_tdata[4*CW-1:0])));
        pairs_sent++;
        if (pairs_sent == 700) hold_off <= 1;
      end
      if (hold_off && !(s_tvalid && s_tready) && expected_lines.size() == 0 && !m_tvalid)
        hold_off <= 0;
      quiet <= pending_pairs.size() < QUIET_TAIL;
      if (s_tvalid && !s_tready) begin
        // hold the item until accepted
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 0;
      end else if (hold_off || (pairs_sent == 700 && s_tvalid && s_tready)) begin
        s_tvalid <= 0;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        send_gap <= $urandom_range(0, 8);
        s_tvalid <= 0;
      end else if (pending_pairs.size() > 0) begin
        s_tvalid <= 1;
        s_tdata <= IN_W'(pending_pairs.pop_front());
      end else begin
        s_tvalid <= 0;
        stimulus_done <= 1;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    line_info_t e;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        vertical_seen += m_tuser[USER_VERTICAL];
        saturated_seen += m_tuser[USER_SATURATE];
        if (expected_lines.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %h", m_tdata);
        end else begin
          e = expected_lines.pop_front();
          if (m_tdata[CW-1:0] !== e.slope || m_tdata[2*CW-1:CW] !== e.mx ||
              m_tdata[3*CW-1:2*CW] !== e.my || m_tdata[4*CW:3*CW] !== e.span ||
              m_tdata[5*CW:4*CW+1] !== e.icpt || m_tuser[USER_VERTICAL] !== e.vert ||
              m_tuser[USER_SATURATE] !== e.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch #%0d: exp slope %h mx %h my %h span %h icpt %h v %b s %b; got slope %h mx %h my %h span %h icpt %h v %b s %b",
                results_seen, e.slope, e.mx, e.my, e.span, e.icpt, e.vert, e.sat,
                m_tdata[CW-1:0], m_tdata[2*CW-1:CW], m_tdata[3*CW-1:2*CW],
                m_tdata[4*CW:3*CW], m_tdata[5*CW:4*CW+1],
                m_tuser[USER_VERTICAL], m_tuser[USER_SATURATE]);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        recv_gap <= $urandom_range(0, 8);
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  // Watchdog and end of run
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_lines.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    wait (stimulus_done);
    wait (expected_lines.size() == 0);
    repeat (2 * LATENCY) @(posedge clk);
    $display("Sent %0d point pairs, checked %0d results (%0d vertical, %0d saturated).",
             pairs_sent, results_seen, vertical_seen, saturated_seen);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
